>>> design/fsts_pkg.sv
// Package for the floor span texture setup block.
// Holds the request and result payload structs and the register indexes; no dependencies.
package fsts_pkg;

	localparam int ROW_W = 10;
	localparam int COL_W = 11;

	// Number of distance light zones; the light_zone field is sized for it.
	localparam int LIGHT_ZONES = 128;

	localparam logic [2:0] REG_VIEW_X       = 3'd0;
	localparam logic [2:0] REG_VIEW_Y       = 3'd1;
	localparam logic [2:0] REG_VIEW_SINE    = 3'd2;
	localparam logic [2:0] REG_VIEW_COSINE  = 3'd3;
	localparam logic [2:0] REG_CENTER_COL   = 3'd4;
	localparam logic [2:0] REG_CENTER_ROW   = 3'd5;
	localparam logic [2:0] REG_PLANE_HEIGHT = 3'd6;
	localparam logic [2:0] REG_FIXED_LIGHT  = 3'd7;

	typedef struct packed {
		logic [9:0]  row;
		logic [10:0] col_start;
		logic [10:0] col_end;
		logic [30:0] row_slope;
	} span_in_t;

	typedef struct packed {
		logic [9:0]         span_row;
		logic [10:0]        span_start;
		logic [10:0]        span_end;
		logic signed [31:0] u_start;
		logic signed [31:0] v_start;
		logic signed [31:0] u_step;
		logic signed [31:0] v_step;
		logic [6:0]         light_zone;
		logic               uses_fixed_light;
	} span_out_t;

	// Operands of one divider cell, handed from cell to cell.
	typedef struct packed {
		logic        valid;
		logic        u_neg;
		logic        v_neg;
		logic [31:0] u_rem;
		logic [31:0] u_quo;
		logic [31:0] v_rem;
		logic [31:0] v_quo;
		logic [9:0]  dy;
	} div_lane_t;

endpackage

>>> design/fsts_div_cell.sv
// One restoring division cell: produces one quotient bit for the u and v steps.
// Depends on fsts_pkg for the lane struct.
module fsts_div_cell
	import fsts_pkg::*;
#(
	parameter int BIT = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_lane_t lane_in,
	output div_lane_t lane_out
);

	div_lane_t nxt;
	div_lane_t lane_q;
	logic [42:0] u_try;
	logic [42:0] v_try;
	logic [42:0] dsh;

	always_comb begin
		nxt   = lane_in;
		dsh   = {33'd0, lane_in.dy} << BIT;
		u_try = {11'd0, lane_in.u_rem};
		v_try = {11'd0, lane_in.v_rem};
		if (u_try >= dsh) begin
			nxt.u_rem = 32'(u_try - dsh);
			nxt.u_quo[BIT] = 1'b1;
		end
		if (v_try >= dsh) begin
			nxt.v_rem = 32'(v_try - dsh);
			nxt.v_quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else if (en) begin
			lane_q <= nxt;
		end
	end

	assign lane_out = lane_q;

endmodule

>>> design/floor_span_texture_setup.sv
// Floor span texture setup: one span request per cycle while the pipe is not stalled.
// Stages: 2 front (multiply, then shift and magnitude), 32 divider cells (one quotient bit each), 3 finish stages.
// Throughput is one span per cycle; the whole pipe stalls while the result is held.
// Reset clears all valid bits and loads the register defaults asynchronously.
// Horizon spans are dropped at entry and produce no result.
module floor_span_texture_setup
	import fsts_pkg::*;
#(
	parameter int LIGHT_SHIFT = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  span_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output span_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int LZ_W = $clog2(LIGHT_ZONES);

	logic signed [31:0] view_x_q, view_y_q, plane_q;
	logic signed [17:0] sine_q, cosine_q;
	logic [10:0] ccol_q;
	logic [9:0]  crow_q;
	logic        fixed_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q <= '0;
			view_y_q <= '0;
			sine_q   <= '0;
			cosine_q <= 18'sd65536;
			ccol_q   <= 11'd160;
			crow_q   <= 10'd100;
			plane_q  <= '0;
			fixed_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VIEW_X:       view_x_q <= cfg_data;
				REG_VIEW_Y:       view_y_q <= cfg_data;
				REG_VIEW_SINE:    sine_q   <= cfg_data[17:0];
				REG_VIEW_COSINE:  cosine_q <= cfg_data[17:0];
				REG_CENTER_COL:   ccol_q   <= cfg_data[10:0];
				REG_CENTER_ROW:   crow_q   <= cfg_data[9:0];
				REG_PLANE_HEIGHT: plane_q  <= {1'b0, cfg_data[30:0]};
				REG_FIXED_LIGHT:  fixed_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The pipe advances unless a finished result is waiting.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [9:0]  dy_full;
	logic        take;
	assign dy_full = (crow_q >= in_data.row) ? crow_q - in_data.row
	                                         : in_data.row - crow_q;
	assign take = in_valid && in_ready && (crow_q != in_data.row);

	// Stage 1: three products.
	logic               v_s1;
	span_in_t           sp_s1;
	logic [9:0]         dy_s1;
	logic signed [63:0] dist_p_s1, usp_s1, vsp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s1     <= in_data;
			dy_s1     <= dy_full;
			dist_p_s1 <= 64'(plane_q) * 64'($signed({1'b0, in_data.row_slope}));
			usp_s1    <= 64'(sine_q) * 64'(plane_q);
			vsp_s1    <= 64'(cosine_q) * 64'(plane_q);
		end
	end

	// Stage 2: shift products, take magnitudes for the divider.
	logic               v_s2;
	span_in_t           sp_s2;
	logic signed [31:0] dist_s2;
	logic [31:0]        dw_u, dw_v;
	div_lane_t          lane [0:32];
	logic               div_u_neg_q, div_v_neg_q;
	logic [31:0]        div_u_q, div_v_q;
	logic [9:0]         div_dy_q;

	assign dw_u = usp_s1[47:16];
	assign dw_v = vsp_s1[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s2   <= sp_s1;
			dist_s2 <= dist_p_s1[47:16];
		end
	end

	always_comb begin
		lane[0].valid = v_s2;
		lane[0].u_neg = div_u_neg_q;
		lane[0].v_neg = div_v_neg_q;
		lane[0].u_rem = div_u_q;
		lane[0].v_rem = div_v_q;
		lane[0].u_quo = '0;
		lane[0].v_quo = '0;
		lane[0].dy    = div_dy_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_u_neg_q <= dw_u[31];
			div_v_neg_q <= dw_v[31];
			div_u_q     <= dw_u[31] ? 32'(-dw_u) : dw_u;
			div_v_q     <= dw_v[31] ? 32'(-dw_v) : dw_v;
			div_dy_q    <= dy_s1;
		end
	end

	for (genvar g = 0; g < 32; g++) begin : g_div
		fsts_div_cell #(.BIT(31 - g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.lane_in (lane[g]),
			.lane_out(lane[g+1])
		);
	end

	// Side delay line carrying the span and distance alongside the divider.
	span_in_t           sd_q   [0:32];
	logic signed [31:0] dd_q   [0:32];
	always_comb begin
		sd_q[0] = sp_s2;
		dd_q[0] = dist_s2;
	end
	for (genvar g = 0; g < 32; g++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sd_q[g+1] <= sd_q[g];
				dd_q[g+1] <= dd_q[g];
			end
		end
	end

	// Finish stage 3: signed steps and start-term products.
	logic               v_s3;
	span_in_t           sp_s3;
	logic signed [31:0] ust_s3, vst_s3;
	logic signed [63:0] cd_s3, sd_s3;
	logic signed [11:0] dx_s3;
	logic signed [31:0] dist_s3;
	div_lane_t          dl;
	assign dl = lane[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= dl.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s3   <= sd_q[32];
			dist_s3 <= dd_q[32];
			ust_s3  <= dl.u_neg ? 32'(-dl.u_quo) : dl.u_quo;
			vst_s3  <= dl.v_neg ? 32'(-dl.v_quo) : dl.v_quo;
			cd_s3   <= 64'(cosine_q) * 64'(dd_q[32]);
			sd_s3   <= 64'(sine_q) * 64'(dd_q[32]);
			dx_s3   <= $signed({1'b0, sd_q[32].col_start}) - $signed({1'b0, ccol_q});
		end
	end

	// Stage 4: column offset products.
	logic               v_s4;
	span_in_t           sp_s4;
	logic signed [31:0] ust_s4, vst_s4, cdf_s4, sdf_s4, dist_s4;
	logic signed [43:0] du_s4, dv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s4   <= sp_s3;
			ust_s4  <= ust_s3;
			vst_s4  <= vst_s3;
			dist_s4 <= dist_s3;
			cdf_s4  <= cd_s3[47:16];
			sdf_s4  <= sd_s3[47:16];
			du_s4   <= 44'(dx_s3) * 44'(ust_s3);
			dv_s4   <= 44'(dx_s3) * 44'(vst_s3);
		end
	end

	// Light zone saturation; a negative distance lands in the last zone, and fixed light forces zone 0.
	logic [LZ_W-1:0] lz;
	logic [31:0]     idx;
	assign idx = 32'(dist_s4) >> LIGHT_SHIFT;
	always_comb begin
		if (fixed_q) lz = '0;
		else if (dist_s4 < 0 || idx >= 32'(LIGHT_ZONES)) lz = LZ_W'(LIGHT_ZONES - 1);
		else lz = LZ_W'(idx);
	end

	// Stage 5: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.span_row   <= sp_s4.row;
			out_data.span_start <= sp_s4.col_start;
			out_data.span_end   <= sp_s4.col_end;
			out_data.u_start    <= view_x_q + cdf_s4 + du_s4[31:0];
			out_data.v_start    <= 32'(0) - view_y_q - sdf_s4 + dv_s4[31:0];
			out_data.u_step     <= ust_s4;
			out_data.v_step     <= vst_s4;
			out_data.light_zone <= 7'(lz);
			out_data.uses_fixed_light <= fixed_q;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.uses_fixed_light |-> out_data.light_zone == 7'd0)
		else $error("fixed light with nonzero zone");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s4) && $stable(v_s3))
		else $error("pipe moved during stall");

endmodule
